// ===== rtl/llct_pkg.sv =====
// Shared types, codes and limits of the log line column tokenizer.
// Used by log_line_column_tokenizer; depends on nothing else.
package llct_pkg;

  // Longest line in bytes; a byte at this position or beyond fails the line
  localparam int unsigned MaxLine = 4096;

  localparam int unsigned OffW = 13;
  localparam int unsigned ColW = 4;

  // Character codes the tokenizer looks for
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChCase  = 8'h20;

  typedef enum logic [1:0] {
    EvStart = 2'd0,
    EvEnd   = 2'd1,
    EvOk    = 2'd2,
    EvFail  = 2'd3
  } event_kind_e;

  // Parser states, one-hot
  typedef enum logic [21:0] {
    StStart   = 22'h000001,
    StCol1    = 22'h000002,
    StCol2    = 22'h000004,
    StCol3    = 22'h000008,
    StCol4    = 22'h000010,
    StQ5      = 22'h000020,
    StSp6     = 22'h000040,
    StCol6    = 22'h000080,
    StCol7    = 22'h000100,
    StCol8    = 22'h000200,
    StQ9      = 22'h000400,
    StSp10    = 22'h000800,
    StCol10   = 22'h001000,
    StQ11     = 22'h002000,
    StSp12    = 22'h004000,
    StQ12     = 22'h008000,
    StSp13    = 22'h010000,
    StQ13     = 22'h020000,
    StSp14    = 22'h040000,
    StQ14     = 22'h080000,
    StDone    = 22'h100000,
    StDiscard = 22'h200000
  } parse_state_e;

  typedef struct packed {
    logic              last;
    logic [OffW-1:0]   offset;
    logic [ColW-1:0]   column;
    event_kind_e       kind;
  } result_t;

  // Build one result entry
  function automatic result_t mk_res(event_kind_e kind, logic [ColW-1:0] col,
                                     logic [OffW-1:0] off);
    result_t r;
    r.kind   = kind;
    r.column = col;
    r.offset = off;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/log_line_column_tokenizer.sv =====
// Log line column tokenizer: one byte per input item, column boundary events out.
// Depends on llct_pkg.
//
// Each accepted byte advances the one-hot column parser and
// loads the up to three results it causes (column start/end events, then the
// ok/fail verdict on the end-of-line byte) into a three-entry output register.
// The output side drains that register one result per cycle while m_axis_tready_i
// is high; bytes that cause zero or one result stream at one byte per cycle
// when the output does not stall, and the next byte is taken in the same cycle
// the last pending result leaves. A line feed in mid-line or a byte at offset
// 4096 or beyond yields a fail verdict and the rest of the line is dropped up
// to its end-of-line byte. Output tdata: event kind, column (0 for verdicts),
// 13-bit byte offset; tlast marks the last result of a byte.
module log_line_column_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_line
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [1:0] event_kind, [5:2] column, [18:6] offset
  output logic        m_axis_tlast_o    // last_of_run
);

  localparam int unsigned OffW = llct_pkg::OffW;

  llct_pkg::parse_state_e state_q, state_d, nxt_st;
  logic [OffW-1:0]        pos_q, pos_d;
  llct_pkg::result_t      slot_q [3];
  llct_pkg::result_t      slot_d [3];
  logic [1:0]             rem_q, rem_d;

  logic [7:0]      c;
  logic            eol;
  logic            is_digit, is_letter, is_upper, is_blank, is_quote, is_dot, is_lf;
  logic [7:0]      lower;
  logic [OffW-1:0] pos_inc, pos_dec;
  logic [1:0]      t_cnt;
  llct_pkg::result_t ev_a, ev_b, verdict;
  llct_pkg::result_t new_slot [3];
  logic [1:0]      new_cnt;
  logic            fail_now;
  logic            load, pop;

  assign c   = s_axis_tdata_i;
  assign eol = s_axis_tlast_i;

  // Character classes
  assign lower     = c | llct_pkg::ChCase;
  assign is_digit  = (c >= 8'h30) && (c <= 8'h39);
  assign is_letter = (lower >= 8'h61) && (lower <= 8'h7A);
  assign is_upper  = (c >= 8'h41) && (c <= 8'h5A);
  assign is_blank  = (c == llct_pkg::ChSpace);
  assign is_quote  = (c == llct_pkg::ChQuote);
  assign is_dot    = (c == llct_pkg::ChDot);
  assign is_lf     = (c == llct_pkg::ChLf);

  assign pos_inc = pos_q + OffW'(1);
  assign pos_dec = pos_q - OffW'(1);

  // Handshakes: take a byte once the pending results are gone or leaving
  assign s_axis_tready_o = (rem_q == 2'd0) || ((rem_q == 2'd1) && m_axis_tready_i);
  assign load            = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (rem_q != 2'd0);
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;

  // Column parser transition
  always_comb begin
    nxt_st = state_q;
    t_cnt  = 2'd0;
    ev_a   = '0;
    ev_b   = '0;
    unique case (state_q)
      llct_pkg::StStart: begin
        ev_a   = llct_pkg::mk_res(llct_pkg::EvStart, 4'd1, pos_q);
        t_cnt  = 2'd1;
        nxt_st = llct_pkg::StCol1;
      end
      llct_pkg::StCol1: begin
        if (!is_digit && is_blank) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvEnd, 4'd1, pos_q);
          ev_b   = llct_pkg::mk_res(llct_pkg::EvStart, 4'd2, pos_inc);
          t_cnt  = 2'd2;
          nxt_st = llct_pkg::StCol2;
        end
      end
      llct_pkg::StCol2: begin
        if (!is_letter && is_blank) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvEnd, 4'd2, pos_q);
          ev_b   = llct_pkg::mk_res(llct_pkg::EvStart, 4'd3, pos_inc);
          t_cnt  = 2'd2;
          nxt_st = llct_pkg::StCol3;
        end
      end
      llct_pkg::StCol3: begin
        if (is_blank) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvEnd, 4'd3, pos_q);
          ev_b   = llct_pkg::mk_res(llct_pkg::EvStart, 4'd4, pos_inc);
          t_cnt  = 2'd2;
          nxt_st = llct_pkg::StCol4;
        end
      end
      llct_pkg::StCol4: begin
        if (is_quote) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvEnd, 4'd4, pos_dec);
          ev_b   = llct_pkg::mk_res(llct_pkg::EvStart, 4'd5, pos_q);
          t_cnt  = 2'd2;
          nxt_st = llct_pkg::StQ5;
        end
      end
      llct_pkg::StQ5: begin
        if (is_quote) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvEnd, 4'd5, pos_inc);
          t_cnt  = 2'd1;
          nxt_st = llct_pkg::StSp6;
        end
      end
      llct_pkg::StSp6: begin
        if (!is_blank) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvStart, 4'd6, pos_q);
          t_cnt  = 2'd1;
          nxt_st = llct_pkg::StCol6;
        end
      end
      llct_pkg::StCol6: begin
        if (!(is_letter || is_dot) && is_blank) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvEnd, 4'd6, pos_q);
          ev_b   = llct_pkg::mk_res(llct_pkg::EvStart, 4'd7, pos_inc);
          t_cnt  = 2'd2;
          nxt_st = llct_pkg::StCol7;
        end
      end
      llct_pkg::StCol7: begin
        if (is_blank) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvEnd, 4'd7, pos_q);
          ev_b   = llct_pkg::mk_res(llct_pkg::EvStart, 4'd8, pos_inc);
          t_cnt  = 2'd2;
          nxt_st = llct_pkg::StCol8;
        end
      end
      llct_pkg::StCol8: begin
        // an upper-case letter or a space is never a quote
        if (!is_upper && is_quote) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvEnd, 4'd8, pos_dec);
          ev_b   = llct_pkg::mk_res(llct_pkg::EvStart, 4'd9, pos_q);
          t_cnt  = 2'd2;
          nxt_st = llct_pkg::StQ9;
        end
      end
      llct_pkg::StQ9: begin
        if (is_quote) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvEnd, 4'd9, pos_inc);
          t_cnt  = 2'd1;
          nxt_st = llct_pkg::StSp10;
        end
      end
      llct_pkg::StSp10: begin
        if (!is_blank) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvStart, 4'd10, pos_q);
          t_cnt  = 2'd1;
          nxt_st = llct_pkg::StCol10;
        end
      end
      llct_pkg::StCol10: begin
        if (!is_digit && is_quote) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvEnd, 4'd10, pos_q);
          ev_b   = llct_pkg::mk_res(llct_pkg::EvStart, 4'd11, pos_q);
          t_cnt  = 2'd2;
          nxt_st = llct_pkg::StQ11;
        end
      end
      llct_pkg::StQ11: begin
        if (is_quote) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvEnd, 4'd11, pos_inc);
          t_cnt  = 2'd1;
          nxt_st = llct_pkg::StSp12;
        end
      end
      llct_pkg::StSp12: begin
        if (!is_blank) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvStart, 4'd12, pos_q);
          t_cnt  = 2'd1;
          nxt_st = llct_pkg::StQ12;
        end
      end
      llct_pkg::StQ12: begin
        if (is_quote) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvEnd, 4'd12, pos_inc);
          t_cnt  = 2'd1;
          nxt_st = llct_pkg::StSp13;
        end
      end
      llct_pkg::StSp13: begin
        if (!is_blank) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvStart, 4'd13, pos_q);
          t_cnt  = 2'd1;
          nxt_st = llct_pkg::StQ13;
        end
      end
      llct_pkg::StQ13: begin
        if (is_quote) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvEnd, 4'd13, pos_inc);
          t_cnt  = 2'd1;
          nxt_st = llct_pkg::StSp14;
        end
      end
      llct_pkg::StSp14: begin
        if (!is_blank) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvStart, 4'd14, pos_q);
          t_cnt  = 2'd1;
          nxt_st = llct_pkg::StQ14;
        end
      end
      llct_pkg::StQ14: begin
        if (is_quote) begin
          ev_a   = llct_pkg::mk_res(llct_pkg::EvEnd, 4'd14, pos_inc);
          t_cnt  = 2'd1;
          nxt_st = llct_pkg::StDone;
        end
      end
      llct_pkg::StDone, llct_pkg::StDiscard: begin
        nxt_st = state_q;
      end
      default: begin
        nxt_st = state_q;
      end
    endcase
  end

  // Early fail: line too long, or a line feed inside the line
  assign fail_now = (32'(pos_q) >= llct_pkg::MaxLine) ||
                    (is_lf && (state_q != llct_pkg::StStart) &&
                     (state_q != llct_pkg::StDone));

  // Assemble the results of this byte: events first, verdict last
  always_comb begin
    verdict = llct_pkg::mk_res((nxt_st == llct_pkg::StDone) ? llct_pkg::EvOk
                                                             : llct_pkg::EvFail,
                               4'd0, pos_q);
    state_d = state_q;
    pos_d   = pos_q;
    if (state_q == llct_pkg::StDiscard) begin
      new_cnt = 2'd0;
      new_slot[0] = verdict;
      new_slot[1] = verdict;
      new_slot[2] = verdict;
      if (eol) begin
        state_d = llct_pkg::StStart;
        pos_d   = '0;
      end
    end else if (fail_now) begin
      new_cnt = 2'd1;
      new_slot[0] = llct_pkg::mk_res(llct_pkg::EvFail, 4'd0, pos_q);
      new_slot[1] = new_slot[0];
      new_slot[2] = new_slot[0];
      if (eol) begin
        state_d = llct_pkg::StStart;
        pos_d   = '0;
      end else begin
        state_d = llct_pkg::StDiscard;
      end
    end else begin
      new_cnt = t_cnt + {1'b0, eol};
      new_slot[0] = (t_cnt > 2'd0) ? ev_a : verdict;
      new_slot[1] = (t_cnt > 2'd1) ? ev_b : verdict;
      new_slot[2] = verdict;
      if (eol) begin
        state_d = llct_pkg::StStart;
        pos_d   = '0;
      end else begin
        state_d = nxt_st;
        pos_d   = pos_inc;
      end
    end
    // mark the last result of this byte
    for (int i = 0; i < 3; i++) begin
      new_slot[i].last = (2'(i + 1) == new_cnt);
    end
  end

  // Load the output register on a new byte, else shift out one result
  always_comb begin
    rem_d     = rem_q;
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    slot_d[2] = slot_q[2];
    if (load) begin
      rem_d     = new_cnt;
      slot_d[0] = new_slot[0];
      slot_d[1] = new_slot[1];
      slot_d[2] = new_slot[2];
    end else if (pop) begin
      rem_d     = rem_q - 2'd1;
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= llct_pkg::StStart;
      pos_q   <= '0;
      rem_q   <= 2'd0;
    end else begin
      rem_q <= rem_d;
      if (load) begin
        state_q <= state_d;
        pos_q   <= pos_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
    slot_q[2] <= slot_d[2];
  end

  assign m_axis_tdata_o = {5'd0, slot_q[0].offset, slot_q[0].column, slot_q[0].kind};
  assign m_axis_tlast_o = slot_q[0].last;

endmodule
